FILE: rtl/core/lwc_pkg.sv
// Shared constants, register codes and word types for the line window clipper.
package lwc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W = 32;
	localparam int OFS_W = 48;
	localparam int TOL_W = 31;
	localparam int DLIM_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int PROD_W = 2 * COORD_W;
	localparam int SHC_W = OFS_W + FRAC_BITS;
	localparam int NUM_W = ((SHC_W > PROD_W) ? SHC_W : PROD_W) + 1;
	localparam int MAG_W = NUM_W - 1;
	localparam int QUO_W = COORD_W;
	localparam int DIV_BITS_PER_STAGE = 4;
	localparam int DIV_STAGES = QUO_W / DIV_BITS_PER_STAGE;
	// product, numerator, divider stages, saturation
	localparam int LANE_STAGES = DIV_STAGES + 3;
	localparam int EXT_W = COORD_W + 2;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT   = 3'd0,
		REG_RIGHT  = 3'd1,
		REG_TOP    = 3'd2,
		REG_BOTTOM = 3'd3,
		REG_TOL    = 3'd4,
		REG_DLIM   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] coef_x;
		logic signed [COORD_W-1:0] coef_y;
		logic signed [OFS_W-1:0]   offset;
	} lwc_in_t;

	typedef struct packed {
		logic                      hit;
		logic signed [COORD_W-1:0] first_x;
		logic signed [COORD_W-1:0] first_y;
		logic signed [COORD_W-1:0] second_x;
		logic signed [COORD_W-1:0] second_y;
	} lwc_out_t;

endpackage

FILE: rtl/core/lwc_solve_lane.sv
// Pipelined solve of -(ofs*2^FRAC_BITS + k*coord) / div, truncated and saturated.
module lwc_solve_lane import lwc_pkg::*; (
	input  logic                      clk,
	input  logic [LANE_STAGES-1:0]    adv,
	input  logic signed [COORD_W-1:0] k,
	input  logic signed [COORD_W-1:0] coord,
	input  logic signed [COORD_W-1:0] div,
	input  logic signed [OFS_W-1:0]   ofs,
	output logic signed [COORD_W-1:0] quo
);

	typedef struct packed {
		logic [COORD_W-1:0] rem;
		logic [QUO_W-1:0]   low;
		logic [QUO_W-1:0]   q;
		logic [COORD_W-1:0] dm;
		logic               neg_q;
		logic               zero;
		logic               ovf;
	} div_state_t;

	function automatic div_state_t div_step(input div_state_t s);
		div_state_t r;
		logic [COORD_W:0] cur;
		r = s;
		for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
			cur = {r.rem, r.low[QUO_W-1]};
			r.low = {r.low[QUO_W-2:0], 1'b0};
			if (cur >= {1'b0, r.dm}) begin
				r.rem = COORD_W'(cur - {1'b0, r.dm});
				r.q = {r.q[QUO_W-2:0], 1'b1};
			end else begin
				r.rem = cur[COORD_W-1:0];
				r.q = {r.q[QUO_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [OFS_W-1:0]   ofs_s1;
	logic signed [COORD_W-1:0] div_s1;

	assign prod = k * coord;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			prod_s1 <= prod;
			ofs_s1 <= ofs;
			div_s1 <= div;
		end
	end

	logic signed [SHC_W-1:0] shc;
	logic signed [NUM_W-1:0] num;
	logic [MAG_W-1:0]        mag;
	logic [COORD_W-1:0]      dm;
	logic [MAG_W-1:0]        mag_s2;
	logic [COORD_W-1:0]      dm_s2;
	logic                    negq_s2;
	logic                    zero_s2;

	assign shc = {ofs_s1, {FRAC_BITS{1'b0}}};
	assign num = NUM_W'(shc) + NUM_W'(prod_s1);
	assign mag = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
	assign dm = div_s1[COORD_W-1] ? COORD_W'(-div_s1) : COORD_W'(div_s1);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			mag_s2 <= mag;
			dm_s2 <= dm;
			// quotient is negative when the numerator sign matches the divisor sign
			negq_s2 <= (num[NUM_W-1] == div_s1[COORD_W-1]);
			zero_s2 <= (num == '0);
		end
	end

	logic [MAG_W-QUO_W-1:0] hi;
	div_state_t             div_init;

	assign hi = mag_s2[MAG_W-1:QUO_W];

	always_comb begin
		div_init.dm = dm_s2;
		div_init.neg_q = negq_s2;
		div_init.zero = zero_s2;
		// quotient needs more than QUO_W bits
		div_init.ovf = ({1'b0, hi} >= (MAG_W-QUO_W+1)'(dm_s2));
		div_init.rem = div_init.ovf ? '0 : COORD_W'(hi);
		div_init.low = mag_s2[QUO_W-1:0];
		div_init.q = '0;
	end

	div_state_t dv_s [DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv[2+j]) begin
				if (j == 0) begin
					dv_s[j] <= div_step(div_init);
				end else begin
					dv_s[j] <= div_step(dv_s[(j == 0) ? 0 : j-1]);
				end
			end
		end
	end

	div_state_t                fin;
	logic signed [COORD_W-1:0] sat;
	logic signed [COORD_W-1:0] quo_sn;

	assign fin = dv_s[DIV_STAGES-1];

	always_comb begin
		if (fin.zero) begin
			sat = '0;
		end else if (fin.ovf) begin
			sat = fin.neg_q ? COORD_MIN : COORD_MAX;
		end else if (fin.neg_q) begin
			sat = fin.q[QUO_W-1] ? COORD_MIN : COORD_W'(-fin.q);
		end else begin
			sat = fin.q[QUO_W-1] ? COORD_MAX : COORD_W'(fin.q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[LANE_STAGES-1]) begin
			quo_sn <= sat;
		end
	end

	assign quo = quo_sn;

endmodule

FILE: rtl/core/line_window_clip.sv
// Top level of the line window clipper.
// Clips the line coef_x*x + coef_y*y + offset = 0 to a configured window.
// Input words arrive on in_valid/in_ready/in_word; one result word per input
// leaves on out_valid/out_ready/out_word, in order.
// Window edges, tolerance and degeneracy limit are written through
// cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high.
// Write configuration only while no words are in flight.
// All four candidate intersections are solved in parallel lanes, each a
// multiplier stage, a numerator stage, eight restoring divider stages
// (four quotient bits each) and a saturation stage; a final stage picks and
// clamps the end points into the output register.
// Throughput: one word per cycle while out_ready stays high.
// A stage holds only while it is full and the next stage is stalled, so bubbles
// are squeezed out and a stalled receiver backs the pipe up without loss.
// Reset clears all valid bits and the configuration registers to zero.
module line_window_clip import lwc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lwc_in_t               in_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lwc_out_t              out_word,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef struct packed {
		logic bdom;
		logic live;
	} sb_t;

	logic signed [COORD_W-1:0] left_q, right_q, top_q, bottom_q;
	logic [TOL_W-1:0]          tol_q;
	logic [DLIM_W-1:0]         dlim_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			right_q <= '0;
			top_q <= '0;
			bottom_q <= '0;
			tol_q <= '0;
			dlim_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LEFT:   left_q <= cfg_data;
				REG_RIGHT:  right_q <= cfg_data;
				REG_TOP:    top_q <= cfg_data;
				REG_BOTTOM: bottom_q <= cfg_data;
				REG_TOL:    tol_q <= cfg_data[TOL_W-1:0];
				REG_DLIM:   dlim_q <= cfg_data[DLIM_W-1:0];
				default: ;
			endcase
		end
	end

	logic signed [COORD_W-1:0] lft, rgt, tp, bot;

	assign lft = (left_q > right_q) ? right_q : left_q;
	assign rgt = (left_q > right_q) ? left_q : right_q;
	assign tp = (top_q > bottom_q) ? bottom_q : top_q;
	assign bot = (top_q > bottom_q) ? top_q : bottom_q;

	logic [LANE_STAGES:0]   rdy;
	logic [LANE_STAGES-1:0] v_q;
	logic                   outv_q;

	always_comb begin
		rdy[LANE_STAGES] = !outv_q || out_ready;
		for (int s = LANE_STAGES - 1; s >= 0; s--) begin
			rdy[s] = !v_q[s] || rdy[s+1];
		end
	end

	assign in_ready = rdy[0];
	assign out_valid = outv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			outv_q <= 1'b0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= in_valid;
			end
			for (int s = 1; s < LANE_STAGES; s++) begin
				if (rdy[s]) begin
					v_q[s] <= v_q[s-1];
				end
			end
			if (rdy[LANE_STAGES]) begin
				outv_q <= v_q[LANE_STAGES-1];
			end
		end
	end

	// dominance and degeneracy ride alongside the lanes
	logic [COORD_W-1:0] ma, mb;
	sb_t                sb_in;
	sb_t                sb_s [LANE_STAGES];

	assign ma = in_word.coef_x[COORD_W-1] ? COORD_W'(-in_word.coef_x) : COORD_W'(in_word.coef_x);
	assign mb = in_word.coef_y[COORD_W-1] ? COORD_W'(-in_word.coef_y) : COORD_W'(in_word.coef_y);

	always_comb begin
		sb_in.bdom = (mb > ma);
		sb_in.live = sb_in.bdom ? (mb > COORD_W'(dlim_q)) : (ma > COORD_W'(dlim_q));
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			sb_s[0] <= sb_in;
		end
		for (int s = 1; s < LANE_STAGES; s++) begin
			if (rdy[s]) begin
				sb_s[s] <= sb_s[s-1];
			end
		end
	end

	logic signed [COORD_W-1:0] yl, yr, xt, xb;

	lwc_solve_lane u_yl (
		.clk(clk), .adv(rdy[LANE_STAGES-1:0]),
		.k(in_word.coef_x), .coord(lft), .div(in_word.coef_y), .ofs(in_word.offset),
		.quo(yl)
	);

	lwc_solve_lane u_yr (
		.clk(clk), .adv(rdy[LANE_STAGES-1:0]),
		.k(in_word.coef_x), .coord(rgt), .div(in_word.coef_y), .ofs(in_word.offset),
		.quo(yr)
	);

	lwc_solve_lane u_xt (
		.clk(clk), .adv(rdy[LANE_STAGES-1:0]),
		.k(in_word.coef_y), .coord(tp), .div(in_word.coef_x), .ofs(in_word.offset),
		.quo(xt)
	);

	lwc_solve_lane u_xb (
		.clk(clk), .adv(rdy[LANE_STAGES-1:0]),
		.k(in_word.coef_y), .coord(bot), .div(in_word.coef_x), .ofs(in_word.offset),
		.quo(xb)
	);

	// tolerance-widened edges, compared without wrap
	logic signed [EXT_W-1:0] tol_x, lo_l, hi_r, lo_t, hi_b;

	assign tol_x = signed'(EXT_W'(tol_q));
	assign lo_l = EXT_W'(lft) - tol_x;
	assign hi_r = EXT_W'(rgt) + tol_x;
	assign lo_t = EXT_W'(tp) - tol_x;
	assign hi_b = EXT_W'(bot) + tol_x;

	sb_t                       sb_l;
	logic                      sw, hit;
	logic signed [COORD_W-1:0] x0, y0, x1, y1;
	lwc_out_t                  res;
	lwc_out_t                  out_s;

	assign sb_l = sb_s[LANE_STAGES-1];

	always_comb begin
		if (sb_l.bdom) begin
			sw = (yl > yr);
			x0 = sw ? rgt : lft;
			y0 = sw ? yr : yl;
			x1 = sw ? lft : rgt;
			y1 = sw ? yl : yr;
			hit = sb_l.live && !((EXT_W'(y0) > hi_b) || (EXT_W'(y1) < lo_t));
			if (EXT_W'(y0) < lo_t) begin
				y0 = tp;
				x0 = xt;
			end
			if (EXT_W'(y1) > hi_b) begin
				y1 = bot;
				x1 = xb;
			end
		end else begin
			sw = (xt > xb);
			x0 = sw ? xb : xt;
			y0 = sw ? bot : tp;
			x1 = sw ? xt : xb;
			y1 = sw ? tp : bot;
			hit = sb_l.live && !((EXT_W'(x0) > hi_r) || (EXT_W'(x1) < lo_l));
			if (EXT_W'(x0) < lo_l) begin
				x0 = lft;
				y0 = yl;
			end
			if (EXT_W'(x1) > hi_r) begin
				x1 = rgt;
				y1 = yr;
			end
		end
		res.hit = hit;
		res.first_x = hit ? x0 : '0;
		res.first_y = hit ? y0 : '0;
		res.second_x = hit ? x1 : '0;
		res.second_y = hit ? y1 : '0;
	end

	always_ff @(posedge clk) begin
		if (rdy[LANE_STAGES]) begin
			out_s <= res;
		end
	end

	assign out_word = out_s;

endmodule

FILE: rtl/core/lwc_checker.sv
// Port-level checks for the line window clipper, bound to the top level.
module lwc_checker import lwc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input lwc_in_t               in_word,
	input logic                  out_valid,
	input logic                  out_ready,
	input lwc_out_t              out_word,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// a miss carries zero end points
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.hit |-> (out_word.first_x == '0) && (out_word.first_y == '0)
			&& (out_word.second_x == '0) && (out_word.second_y == '0))
		else $error("miss with nonzero end points");

	// with nothing waiting at the output the whole pipe can move
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// reset leaves no result behind
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result word present after reset");

endmodule

bind line_window_clip lwc_checker u_lwc_checker (.*);
